// ===== hw/rtl/rma_pkg.sv =====
// Shared types, codes and constants of the register machine ALU.
// No dependencies; every other file of the block imports this package.
package rma_pkg;

	localparam int NUM_REGS_DEF = 26;
	localparam int DATA_W_DEF   = 32;

	localparam int FUNC_W = 4;
	localparam int IDX_W  = 5;
	localparam int VAL_W  = 32;

	// instruction queue between front and back
	localparam int QDEPTH = 2;
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [FUNC_W-1:0] FN_IN   = 4'd0;
	localparam logic [FUNC_W-1:0] FN_MOV  = 4'd1;
	localparam logic [FUNC_W-1:0] FN_XCHG = 4'd2;
	localparam logic [FUNC_W-1:0] FN_ADD  = 4'd3;
	localparam logic [FUNC_W-1:0] FN_SUB  = 4'd4;
	localparam logic [FUNC_W-1:0] FN_MUL  = 4'd5;
	localparam logic [FUNC_W-1:0] FN_DIV  = 4'd6;
	localparam logic [FUNC_W-1:0] FN_MOD  = 4'd7;
	localparam logic [FUNC_W-1:0] FN_AND  = 4'd8;
	localparam logic [FUNC_W-1:0] FN_OR   = 4'd9;
	localparam logic [FUNC_W-1:0] FN_XOR  = 4'd10;
	localparam logic [FUNC_W-1:0] FN_OUT  = 4'd11;

	typedef enum logic [2:0] {
		CL_LOAD,
		CL_MOV,
		CL_XCHG,
		CL_OUT,
		CL_ALU,
		CL_MDU
	} op_class_t;

	// src0/src1 are the indexes for the two register file read ports
	typedef struct packed {
		op_class_t          cls;
		logic [FUNC_W-1:0]  func;
		logic [IDX_W-1:0]   dest;
		logic [IDX_W-1:0]   src0;
		logic [IDX_W-1:0]   src1;
		logic [VAL_W-1:0]   imm;
	} instr_t;

	typedef struct packed {
		logic   valid;
		instr_t head;
	} q_link_t;

	typedef struct packed {
		logic              start;
		logic [FUNC_W-1:0] func;
	} mdu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mdu_stat_t;

	typedef struct packed {
		logic idle;
		logic mdu_busy;
	} back_stat_t;

endpackage

// ===== hw/rtl/rma_if.sv =====
// Valid/ready channel interfaces: instruction beats in, result beats out.
// Depends on rma_pkg for field widths.
interface rma_cmd_if import rma_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic [IDX_W-1:0]         dest_reg;
	logic [IDX_W-1:0]         first_src;
	logic [IDX_W-1:0]         second_src;
	logic                     three_operand;
	logic signed [VAL_W-1:0]  immediate;

	modport source (
		output valid, func, dest_reg, first_src, second_src, three_operand, immediate,
		input  ready
	);
	modport sink (
		input  valid, func, dest_reg, first_src, second_src, three_operand, immediate,
		output ready
	);
endinterface

interface rma_res_if import rma_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [VAL_W-1:0]  out_value;
	logic                     div_by_zero;

	modport source (
		output valid, out_value, div_by_zero,
		input  ready
	);
	modport sink (
		input  valid, out_value, div_by_zero,
		output ready
	);
endinterface

// ===== hw/rtl/register_machine_alu.sv =====
// Register machine ALU: executes decoded instructions over a register file.
//
// cmd (valid/ready sink): one decoded instruction per beat. Undefined func
//   codes are taken and dropped. A two-entry queue sits behind the front end,
//   so cmd.ready stays high until two instructions are waiting.
// res (valid/ready source): one beat per OUT, and one error beat
//   (out_value 0, div_by_zero 1) per DIV or MOD by zero.
// Timing: the back end pops one instruction at a time and runs it in ST_EXEC;
//   XCHG adds ST_XCHG, and MUL, DIV and MOD wait in ST_MDU on the
//   one-bit-per-cycle multiply / divide unit, which a zero divisor skips.
//   An OUT passes through the queue, is popped in ST_IDLE, and in ST_EXEC
//   loads the result register that drives res.valid.
// Reset: all registers read as zero (per-entry valid bits), the queue and the
//   result register are empty; instructions are taken right after reset.
// Stall: a result waits in the output register; an OUT or error result that
//   finds it full holds the back end, and the queue then fills and drops
//   cmd.ready. Register indexes at or past NUM_REGS read zero, writes dropped.
// Depends on rma_pkg, rma_if, rma_front, rma_back (and rma_mdu).
module register_machine_alu import rma_pkg::*; #(
	parameter int NUM_REGS   = NUM_REGS_DEF,
	parameter int DATA_WIDTH = DATA_W_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rma_cmd_if.sink   cmd,
	rma_res_if.source res
);

	q_link_t           q;
	logic              q_pop;
	logic [QCNT_W-1:0] q_count;
	back_stat_t        bstat;

	rma_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q       (q),
		.q_pop   (q_pop),
		.q_count (q_count)
	);

	rma_back #(
		.NUM_REGS (NUM_REGS),
		.DW       (DATA_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q      (q),
		.q_pop  (q_pop),
		.stat   (bstat),
		.res    (res)
	);

`ifndef SYNTHESIS
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QDEPTH))
		else $error("instruction queue over depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q.valid)
		else $error("pop from empty instruction queue");

	a_pop_mdu_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (bstat.idle && !bstat.mdu_busy))
		else $error("pop while back end busy");

	a_pop_exec: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !bstat.idle)
		else $error("popped instruction not executed");
`endif

endmodule

// ===== hw/rtl/rma_front.sv =====
// Front end: accepts instruction beats, classifies them, and queues them.
// Depends on rma_pkg and rma_cmd_if.
module rma_front import rma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	rma_cmd_if.sink           cmd,
	output q_link_t           q,
	input  logic              q_pop,
	output logic [QCNT_W-1:0] q_count
);

	instr_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0]   wp_q;
	logic [QPTR_W-1:0]   rp_q;
	logic [QCNT_W-1:0]   cnt_q;

	instr_t dec;
	logic   fn_ok;
	logic   push;

	always_comb begin
		fn_ok    = 1'b1;
		dec.cls  = CL_ALU;
		dec.func = cmd.func;
		dec.dest = cmd.dest_reg;
		dec.src0 = cmd.dest_reg;
		dec.src1 = cmd.first_src;
		dec.imm  = cmd.immediate;
		unique case (cmd.func) inside
			FN_IN: begin
				dec.cls = CL_LOAD;
			end
			FN_MOV: begin
				dec.cls = CL_MOV;
			end
			FN_XCHG: begin
				dec.cls = CL_XCHG;
			end
			FN_OUT: begin
				dec.cls = CL_OUT;
			end
			FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR: begin
				dec.cls  = CL_ALU;
				dec.src0 = cmd.three_operand ? cmd.first_src  : cmd.dest_reg;
				dec.src1 = cmd.three_operand ? cmd.second_src : cmd.first_src;
			end
			FN_MUL, FN_DIV, FN_MOD: begin
				dec.cls  = CL_MDU;
				dec.src0 = cmd.three_operand ? cmd.first_src  : cmd.dest_reg;
				dec.src1 = cmd.three_operand ? cmd.second_src : cmd.first_src;
			end
			default: begin
				fn_ok = 1'b0;	// undefined codes are taken and dropped
			end
		endcase
	end

	assign cmd.ready = (cnt_q != QCNT_W'(QDEPTH));
	assign push      = cmd.valid && cmd.ready && fn_ok;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + QPTR_W'(1);
			end
			if (q_pop) begin
				rp_q <= rp_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(q_pop);
		end
	end

	assign q.valid = (cnt_q != '0);
	assign q.head  = ent_q[rp_q];
	assign q_count = cnt_q;

endmodule

// ===== hw/rtl/rma_mdu.sv =====
// Iterative multiply / divide unit: one shift-add or one restoring
// subtract step per cycle. Depends on rma_pkg.
module rma_mdu import rma_pkg::*; #(
	parameter int DW = DATA_W_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mdu_ctl_t      ctl,
	input  logic [DW-1:0] op_a,
	input  logic [DW-1:0] op_b,
	output mdu_stat_t     stat,
	output logic [DW-1:0] result
);

	localparam int CNT_W = $clog2(DW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             mul_q;
	logic             mod_q;
	logic             qneg_q;
	logic             rneg_q;
	logic [DW-1:0]    acc_q;
	logic [DW-1:0]    x_q;
	logic [DW-1:0]    y_q;

	logic [DW:0]      sh;
	logic [DW:0]      diff;
	logic             fits;

	// restoring step: shift the next dividend bit into the remainder
	assign sh   = {acc_q, x_q[DW-1]};
	assign diff = sh - {1'b0, y_q};
	assign fits = !diff[DW];

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mul_q  <= (ctl.func == FN_MUL);
			mod_q  <= (ctl.func == FN_MOD);
			qneg_q <= op_a[DW-1] ^ op_b[DW-1];
			rneg_q <= op_a[DW-1];
			acc_q  <= '0;
			if (ctl.func == FN_MUL) begin
				x_q <= op_a;
				y_q <= op_b;
			end else begin
				x_q <= op_a[DW-1] ? -op_a : op_a;
				y_q <= op_b[DW-1] ? -op_b : op_b;
			end
		end else if (busy_q) begin
			if (mul_q) begin
				acc_q <= acc_q + (y_q[0] ? x_q : '0);
				x_q   <= {x_q[DW-2:0], 1'b0};
				y_q   <= {1'b0, y_q[DW-1:1]};
			end else begin
				acc_q <= fits ? diff[DW-1:0] : sh[DW-1:0];
				x_q   <= {x_q[DW-2:0], fits};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (mul_q) begin
			result = acc_q;
		end else if (mod_q) begin
			result = rneg_q ? -acc_q : acc_q;
		end else begin
			result = qneg_q ? -x_q : x_q;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== hw/rtl/rma_back.sv =====
// Back end: register file with per-entry valid bits, execute sequencer and
// result register. Depends on rma_pkg, rma_res_if and rma_mdu.
module rma_back import rma_pkg::*; #(
	parameter int NUM_REGS = NUM_REGS_DEF,
	parameter int DW       = DATA_W_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  q_link_t    q,
	output logic       q_pop,
	output back_stat_t stat,
	rma_res_if.source  res
);

	localparam int AW = $clog2(NUM_REGS);
	localparam int IW = (AW > IDX_W) ? AW : IDX_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_XCHG = 2'd2;
	localparam logic [1:0] ST_MDU  = 2'd3;

	logic [1:0]          state_q;
	logic [1:0]          state_nx;

	logic [DW-1:0]       mem [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;

	instr_t              cur_q;
	logic [DW-1:0]       rd0_q;
	logic [DW-1:0]       rd1_q;
	logic                rd0_ok_q;
	logic                rd1_ok_q;

	logic                res_valid_q;
	logic [VAL_W-1:0]    res_value_q;
	logic                res_dz_q;

	logic [IW-1:0]       ra0_ext;
	logic [IW-1:0]       ra1_ext;
	logic [IW-1:0]       wa_ext;
	logic [AW-1:0]       ra0;
	logic [AW-1:0]       ra1;
	logic [AW-1:0]       wa;
	logic                ra0_in;
	logic                ra1_in;

	logic [DW-1:0]       a_val;
	logic [DW-1:0]       b_val;
	logic [DW-1:0]       alu_res;
	logic [DW-1:0]       imm_ext;
	logic                res_free;

	logic                we_req;
	logic                wr_en;
	logic [IDX_W-1:0]    widx;
	logic [DW-1:0]       wdata;
	logic                res_load;
	logic [VAL_W-1:0]    res_val;
	logic                res_dz;

	mdu_ctl_t            mdu_ctl;
	mdu_stat_t           mdu_st;
	logic [DW-1:0]       mdu_res;

	rma_mdu #(.DW(DW)) u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mdu_ctl),
		.op_a   (a_val),
		.op_b   (b_val),
		.stat   (mdu_st),
		.result (mdu_res)
	);

	// index to address; indexes at or past NUM_REGS read as zero
	assign ra0_ext = IW'(q.head.src0);
	assign ra1_ext = IW'(q.head.src1);
	assign wa_ext  = IW'(widx);
	assign ra0     = ra0_ext[AW-1:0];
	assign ra1     = ra1_ext[AW-1:0];
	assign wa      = wa_ext[AW-1:0];
	assign ra0_in  = int'(q.head.src0) < NUM_REGS;
	assign ra1_in  = int'(q.head.src1) < NUM_REGS;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q    <= q.head;
			rd0_q    <= mem[ra0];
			rd1_q    <= mem[ra1];
			rd0_ok_q <= ra0_in && vld_q[ra0];
			rd1_ok_q <= ra1_in && vld_q[ra1];
		end
		if (wr_en) begin
			mem[wa] <= wdata;
		end
	end

	assign a_val   = rd0_ok_q ? rd0_q : '0;
	assign b_val   = rd1_ok_q ? rd1_q : '0;
	assign imm_ext = DW'(signed'(cur_q.imm));

	always_comb begin
		case (cur_q.func)
			FN_ADD:  alu_res = a_val + b_val;
			FN_SUB:  alu_res = a_val - b_val;
			FN_AND:  alu_res = a_val & b_val;
			FN_OR:   alu_res = a_val | b_val;
			default: alu_res = a_val ^ b_val;
		endcase
	end

	assign res_free = !res_valid_q || res.ready;

	always_comb begin
		state_nx      = state_q;
		q_pop         = 1'b0;
		we_req        = 1'b0;
		widx          = cur_q.dest;
		wdata         = alu_res;
		res_load      = 1'b0;
		res_val       = '0;
		res_dz        = 1'b0;
		mdu_ctl.start = 1'b0;
		mdu_ctl.func  = cur_q.func;
		unique case (state_q)
			ST_IDLE: begin
				if (q.valid) begin
					q_pop    = 1'b1;
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (cur_q.cls)
					CL_LOAD: begin
						we_req   = 1'b1;
						wdata    = imm_ext;
						state_nx = ST_IDLE;
					end
					CL_MOV: begin
						we_req   = 1'b1;
						wdata    = b_val;
						state_nx = ST_IDLE;
					end
					CL_XCHG: begin
						we_req   = 1'b1;
						wdata    = b_val;
						state_nx = ST_XCHG;
					end
					CL_OUT: begin
						if (res_free) begin
							res_load = 1'b1;
							res_val  = VAL_W'(signed'(a_val));
							state_nx = ST_IDLE;
						end
					end
					CL_ALU: begin
						we_req   = 1'b1;
						state_nx = ST_IDLE;
					end
					CL_MDU: begin
						if (cur_q.func != FN_MUL && b_val == '0) begin
							if (res_free) begin
								res_load = 1'b1;
								res_dz   = 1'b1;
								state_nx = ST_IDLE;
							end
						end else begin
							mdu_ctl.start = 1'b1;
							state_nx      = ST_MDU;
						end
					end
					default: begin
						state_nx = ST_IDLE;
					end
				endcase
			end
			ST_XCHG: begin
				// second half of the swap: old dest value goes to first_src
				we_req   = 1'b1;
				widx     = cur_q.src1;
				wdata    = a_val;
				state_nx = ST_IDLE;
			end
			ST_MDU: begin
				if (mdu_st.done) begin
					we_req   = 1'b1;
					wdata    = mdu_res;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	assign wr_en = we_req && (int'(widx) < NUM_REGS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (wr_en) begin
				vld_q[wa] <= 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_value_q <= res_val;
			res_dz_q    <= res_dz;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.out_value   = res_value_q;
	assign res.div_by_zero = res_dz_q;

	assign stat.idle     = (state_q == ST_IDLE);
	assign stat.mdu_busy = mdu_st.busy;

endmodule

// ===== tb/sv/tb_register_machine_alu.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for register_machine_alu: a directed table, then random
// instruction streams, checked against a shadow register file. Needs rma_pkg, rma_if, RTL.
module tb_register_machine_alu;
	import rma_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int RESET_CYCLES = 12;
	localparam int NREGS        = NUM_REGS_DEF;
	localparam int TOTAL_ITEMS  = 1550;
	localparam int CALM_ITEMS   = 150;
	localparam int LONG_HOLD    = 200;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 60;

	localparam logic [FUNC_W-1:0] FN_UNDEF_HI = 4'd15;

	localparam logic [IDX_W-1:0] R_A = 5'd0;
	localparam logic [IDX_W-1:0] R_B = 5'd1;
	localparam logic [IDX_W-1:0] R_C = 5'd2;
	localparam logic [IDX_W-1:0] R_D = 5'd3;
	localparam logic [IDX_W-1:0] R_E = 5'd4;
	localparam logic [IDX_W-1:0] R_F = 5'd5;
	localparam logic [IDX_W-1:0] R_G = 5'd6;
	localparam logic [IDX_W-1:0] R_H = 5'd7;
	localparam logic [IDX_W-1:0] R_I = 5'd8;
	localparam logic [IDX_W-1:0] R_J = 5'd9;
	localparam logic [IDX_W-1:0] R_K = 5'd10;
	localparam logic [IDX_W-1:0] R_L = 5'd11;
	localparam logic [IDX_W-1:0] R_Z = 5'd25;
	localparam logic [IDX_W-1:0] R_PAST = 5'd30;
	localparam logic [IDX_W-1:0] R_TOP  = 5'd31;

	localparam logic [VAL_W-1:0] V_MAX  = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] V_MIN  = 32'h8000_0000;
	localparam logic [VAL_W-1:0] V_ONES = 32'hFFFF_FFFF;

	typedef struct {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0]  dest_reg;
		logic [IDX_W-1:0]  first_src;
		logic [IDX_W-1:0]  second_src;
		logic              three_operand;
		logic [VAL_W-1:0]  immediate;
		bit                pinned;
		logic [VAL_W-1:0]  pin_value;
		bit                pin_dbz;
	} instr_beat_t;

	typedef struct {
		logic [VAL_W-1:0] value;
		logic             dbz;
	} out_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	rma_cmd_if cmd_bus ();
	rma_res_if res_bus ();

	register_machine_alu uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.res    (res_bus)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	logic [VAL_W-1:0] shadow_regs [NREGS];
	out_beat_t        pending_outs [$];
	instr_beat_t      cur_instr;
	bit               cmd_took;
	bit               hold_off_req;
	bit               calm;
	int               fail_count;
	int               n_results;
	int               n_dbz;
	int               idle_cycles;

	function automatic logic [VAL_W-1:0] reg_read(input logic [IDX_W-1:0] idx);
		return (idx < NREGS) ? shadow_regs[idx] : '0;
	endfunction

	function automatic void reg_write(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] v);
		if (idx < NREGS)
			shadow_regs[idx] = v;
	endfunction

	// Applies one instruction to the shadow file; returns 1 when it emits a beat.
	function automatic bit exec_instr(
		input  logic [FUNC_W-1:0] fn,
		input  logic [IDX_W-1:0]  d,
		input  logic [IDX_W-1:0]  s1,
		input  logic [IDX_W-1:0]  s2,
		input  logic              three,
		input  logic [VAL_W-1:0]  imm,
		output out_beat_t         res
	);
		logic [VAL_W-1:0]          a, b, t;
		logic signed [2*VAL_W-1:0] wa, wb, q;
		res.value = '0;
		res.dbz   = 1'b0;
		a  = three ? reg_read(s1) : reg_read(d);
		b  = three ? reg_read(s2) : reg_read(s1);
		wa = $signed(a);
		wb = $signed(b);
		case (fn)
			FN_IN:   reg_write(d, imm);
			FN_MOV:  reg_write(d, reg_read(s1));
			FN_XCHG: begin
				t = reg_read(d);
				reg_write(d, reg_read(s1));
				reg_write(s1, t);
			end
			FN_OUT: begin
				res.value = reg_read(d);
				return 1'b1;
			end
			FN_ADD:  reg_write(d, a + b);
			FN_SUB:  reg_write(d, a - b);
			FN_MUL:  reg_write(d, a * b);
			FN_DIV, FN_MOD: begin
				if (b == '0) begin
					res.dbz = 1'b1;
					return 1'b1;
				end
				// 64-bit math keeps min / -1 defined; low half is the wrapped answer
				q = (fn == FN_DIV) ? wa / wb : wa % wb;
				reg_write(d, q[VAL_W-1:0]);
			end
			FN_AND:  reg_write(d, a & b);
			FN_OR:   reg_write(d, a | b);
			FN_XOR:  reg_write(d, a ^ b);
			default: ;
		endcase
		return 1'b0;
	endfunction

	function automatic instr_beat_t make_instr(
		input logic [FUNC_W-1:0] fn,
		input logic [IDX_W-1:0]  d,
		input logic [IDX_W-1:0]  s1,
		input logic [IDX_W-1:0]  s2,
		input logic              three,
		input logic [VAL_W-1:0]  imm
	);
		instr_beat_t b;
		b.func          = fn;
		b.dest_reg      = d;
		b.first_src     = s1;
		b.second_src    = s2;
		b.three_operand = three;
		b.immediate     = imm;
		b.pinned        = 1'b0;
		b.pin_value     = '0;
		b.pin_dbz       = 1'b0;
		return b;
	endfunction

	function automatic instr_beat_t with_result(
		input instr_beat_t b, input logic [VAL_W-1:0] v, input bit dbz
	);
		instr_beat_t r;
		r           = b;
		r.pinned    = 1'b1;
		r.pin_value = v;
		r.pin_dbz   = dbz;
		return r;
	endfunction

	// Mostly real registers, now and then an index past the file.
	function automatic logic [IDX_W-1:0] rand_idx();
		return ($urandom_range(0, 19) == 0) ? IDX_W'($urandom_range(NREGS, 31))
			: IDX_W'($urandom_range(0, NREGS - 1));
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_instr(input instr_beat_t b);
		cur_instr = b;
		cmd_bus.valid         <= 1'b1;
		cmd_bus.func          <= b.func;
		cmd_bus.dest_reg      <= b.dest_reg;
		cmd_bus.first_src     <= b.first_src;
		cmd_bus.second_src    <= b.second_src;
		cmd_bus.three_operand <= b.three_operand;
		cmd_bus.immediate     <= b.immediate;
		do @(negedge clk); while (!cmd_took);
	endtask

	always @(posedge clk) begin : scoreboard
		out_beat_t want, pred;
		bit        cmd_fire, res_fire, emits;
		cmd_fire = cmd_bus.valid && cmd_bus.ready;
		res_fire = res_bus.valid && res_bus.ready;
		if (res_fire) begin
			n_results++;
			if (res_bus.div_by_zero === 1'b1)
				n_dbz++;
			if (pending_outs.size() == 0) begin
				$error("unexpected result beat: out_value %0d div_by_zero %0b",
					res_bus.out_value, res_bus.div_by_zero);
				fail_count++;
			end else begin
				want = pending_outs.pop_front();
				if (res_bus.out_value !== want.value) begin
					$error("out_value: expected %0d, got %0d", $signed(want.value),
						res_bus.out_value);
					fail_count++;
				end
				if (res_bus.div_by_zero !== want.dbz) begin
					$error("div_by_zero: expected %0b, got %0b", want.dbz,
						res_bus.div_by_zero);
					fail_count++;
				end
			end
		end
		if (cmd_fire) begin
			emits = exec_instr(cmd_bus.func, cmd_bus.dest_reg, cmd_bus.first_src,
				cmd_bus.second_src, cmd_bus.three_operand, cmd_bus.immediate, pred);
			if (emits) begin
				if (cur_instr.pinned) begin
					pred.value = cur_instr.pin_value;
					pred.dbz   = cur_instr.pin_dbz;
				end
				pending_outs.push_back(pred);
			end
		end
		cmd_took = cmd_fire;
		idle_cycles = (cmd_fire || res_fire) ? 0 : idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side: random stall bursts, plus the long hold-off on request.
	initial begin : res_sink
		int stall, odds, tick;
		tick = 0;
		odds = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			tick++;
			if (tick % 128 == 0)
				odds = $urandom_range(0, 3);
			if (hold_off_req) begin
				res_bus.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_off_req = 1'b0;
				res_bus.ready <= 1'b1;
			end else if (!calm && odds != 0 && $urandom_range(0, odds * 2) == 0) begin
				stall = $urandom_range(1, 5);
				res_bus.ready <= 1'b0;
				repeat (stall) @(negedge clk);
				res_bus.ready <= 1'b1;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		instr_beat_t      directed [$];
		instr_beat_t      b;
		logic [FUNC_W-1:0] fn;
		logic [VAL_W-1:0] imm;
		int               n_items, n_directed, send_odds, r;

		arst_n                = 1'b0;
		cmd_bus.valid         = 1'b0;
		cmd_bus.func          = FN_IN;
		cmd_bus.dest_reg      = '0;
		cmd_bus.first_src     = '0;
		cmd_bus.second_src    = '0;
		cmd_bus.three_operand = 1'b0;
		cmd_bus.immediate     = '0;
		res_bus.ready         = 1'b0;
		cmd_took     = 1'b0;
		hold_off_req = 1'b0;
		calm         = 1'b0;
		fail_count   = 0;
		n_results    = 0;
		n_dbz        = 0;
		idle_cycles  = 0;
		foreach (shadow_regs[i])
			shadow_regs[i] = '0;
		cur_instr = make_instr(FN_IN, R_A, R_A, R_A, 1'b0, '0);

		// registers read zero after reset
		directed.push_back(with_result(make_instr(FN_OUT, R_A, R_B, R_C, 1'b0, '0), '0, 1'b0));
		directed.push_back(with_result(make_instr(FN_OUT, R_Z, R_Z, R_TOP, 1'b1, V_ONES),
			'0, 1'b0));
		directed.push_back(make_instr(FN_IN, R_A, R_TOP, R_TOP, 1'b0, V_MAX));
		directed.push_back(make_instr(FN_IN, R_B, R_A, R_Z, 1'b1, V_MIN));
		directed.push_back(make_instr(FN_IN, R_C, R_A, R_A, 1'b0, V_ONES));
		directed.push_back(with_result(make_instr(FN_OUT, R_A, R_A, R_A, 1'b0, '0), V_MAX, 1'b0));
		directed.push_back(with_result(make_instr(FN_OUT, R_B, R_A, R_A, 1'b1, '0), V_MIN, 1'b0));
		// min / -1 wraps to min, remainder zero
		directed.push_back(make_instr(FN_DIV, R_D, R_B, R_C, 1'b1, '0));
		directed.push_back(make_instr(FN_MOD, R_E, R_B, R_C, 1'b1, '0));
		directed.push_back(with_result(make_instr(FN_OUT, R_D, R_A, R_A, 1'b0, '0), V_MIN, 1'b0));
		directed.push_back(with_result(make_instr(FN_OUT, R_E, R_A, R_A, 1'b0, '0), '0, 1'b0));
		// zero divisor: error beat, nothing written
		directed.push_back(with_result(make_instr(FN_DIV, R_A, R_F, R_B, 1'b0, '0), '0, 1'b1));
		directed.push_back(with_result(make_instr(FN_MOD, R_G, R_A, R_Z, 1'b1, '0), '0, 1'b1));
		directed.push_back(make_instr(FN_ADD, R_H, R_A, R_A, 1'b1, '0));
		directed.push_back(make_instr(FN_SUB, R_I, R_B, R_A, 1'b1, '0));
		directed.push_back(make_instr(FN_MUL, R_A, R_B, R_Z, 1'b0, '0));
		directed.push_back(make_instr(FN_AND, R_J, R_A, R_C, 1'b1, '0));
		directed.push_back(make_instr(FN_OR, R_B, R_C, R_TOP, 1'b0, '0));
		directed.push_back(make_instr(FN_XOR, R_K, R_A, R_C, 1'b1, '0));
		directed.push_back(make_instr(FN_MOV, R_L, R_B, R_Z, 1'b1, '0));
		directed.push_back(make_instr(FN_XCHG, R_L, R_C, R_A, 1'b0, '0));
		// indexes past the file: write dropped, read zero
		directed.push_back(make_instr(FN_IN, R_TOP, R_A, R_A, 1'b0, 32'h1234_5678));
		directed.push_back(with_result(make_instr(FN_OUT, R_TOP, R_A, R_A, 1'b0, '0), '0, 1'b0));
		directed.push_back(make_instr(FN_XCHG, R_D, R_PAST, R_A, 1'b0, '0));
		directed.push_back(make_instr(FN_UNDEF_HI, R_A, R_B, R_C, 1'b1, V_ONES));
		directed.push_back(make_instr(FN_OUT, R_L, R_A, R_A, 1'b0, '0));

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		n_items = 0;
		foreach (directed[i]) begin
			send_instr(directed[i]);
			if (directed[i].func <= FN_OUT)
				n_items++;
		end
		n_directed = n_items;

		send_odds = 0;
		while (n_items < TOTAL_ITEMS) begin
			if (n_items % 100 == 0)
				send_odds = $urandom_range(0, 3);
			calm = (n_items >= TOTAL_ITEMS - CALM_ITEMS);
			if (n_items == 300 || n_items == 1000)
				hold_off_req = 1'b1;

			r = $urandom_range(0, 99);
			if (r < 3)       fn = FUNC_W'($urandom_range(12, 15));
			else if (r < 16) fn = FN_IN;
			else if (r < 30) fn = FN_OUT;
			else if (r < 36) fn = FN_MOV;
			else if (r < 41) fn = FN_XCHG;
			else if (r < 51) fn = FN_ADD;
			else if (r < 59) fn = FN_SUB;
			else if (r < 65) fn = FN_MUL;
			else if (r < 73) fn = FN_DIV;
			else if (r < 81) fn = FN_MOD;
			else if (r < 87) fn = FN_AND;
			else if (r < 93) fn = FN_OR;
			else             fn = FN_XOR;

			// small values and zeros keep divides and zero divisors coming
			r = $urandom_range(0, 9);
			if (r == 0) begin
				case ($urandom_range(0, 4))
					0: imm = '0;
					1: imm = 32'd1;
					2: imm = V_ONES;
					3: imm = V_MIN;
					default: imm = V_MAX;
				endcase
			end else if (r < 4) begin
				imm = VAL_W'($urandom_range(0, 40)) - 32'd20;
			end else begin
				imm = $urandom();
			end

			b = make_instr(fn, rand_idx(), rand_idx(), rand_idx(), 1'($urandom_range(0, 1)), imm);
			send_instr(b);
			if (b.func <= FN_OUT)
				n_items++;
			if (!calm && send_odds != 0 && $urandom_range(0, send_odds * 2) == 0) begin
				cmd_bus.valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
		end
		cmd_bus.valid <= 1'b0;

		wait (pending_outs.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_outs.size() != 0) begin
			$error("%0d expected result beats never arrived", pending_outs.size());
			fail_count++;
		end

		$display("Ran %0d instructions (%0d from the directed table) over all 12 operations,",
			n_items, n_directed);
		$display("checked %0d result beats, %0d of them divide-by-zero errors; %0d mismatches.",
			n_results, n_dbz, fail_count);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
